### hw/rtl/lct_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lct_pkg
// Shared widths, codes and control types of the load cell tare and scale block.
// ----------------------------------------------------------------------------
package lct_pkg;

    localparam int FIELD_CORNERS = 4;
    localparam int RAW_W         = 24;
    localparam int SCALE_W       = 32;
    localparam int WEIGHT_W      = 32;
    localparam int TOTAL_W       = 34;
    localparam int DIFF_W        = RAW_W + 1;
    localparam int PROD_W        = DIFF_W + SCALE_W;
    localparam int FRAC_SHIFT    = 14;
    localparam int SH_W          = PROD_W - FRAC_SHIFT;
    localparam int REM_W         = 8;
    localparam int OP_W          = 2;
    localparam int IDX_W         = 2;
    localparam int CFG_IDX_W     = 2;

    localparam int IN_TDATA_W    = 128;
    localparam int OUT_TDATA_W   = 264;

    // lane pipeline depth, plus one output stage in the merge
    localparam int LANE_D        = 7;
    localparam int PIPE_D        = LANE_D + 1;

    localparam int NUM_CORNERS_DEF    = 4;
    localparam int TARE_SAMPLES_DEF   = 20;
    localparam int DEFAULT_OFFSET_DEF = 0;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 32'h4000_0000;

    localparam logic [OP_W-1:0] OP_FRAME = 2'd0;
    localparam logic [OP_W-1:0] OP_TARE  = 2'd1;
    localparam logic [OP_W-1:0] OP_LOAD  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_SCALE0 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE1 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE3 = 2'd3;

    typedef struct packed {
        logic              frame;
        logic              accum;
        logic              clear;
        logic              fin;
        logic              load;
        logic [LANE_D-1:0] adv;
    } t_lane_ctl;

    typedef struct packed {
        logic busy;
        logic seen;
    } t_status;

endpackage

### hw/rtl/lct_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lct_lane
// One corner: raw store, tare accumulator and divide, offset store, weight.
// ----------------------------------------------------------------------------
module lct_lane #(
    parameter int TARE_SAMPLES   = lct_pkg::TARE_SAMPLES_DEF,
    parameter int DEFAULT_OFFSET = lct_pkg::DEFAULT_OFFSET_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  lct_pkg::t_lane_ctl                   i_ctl,
    input  logic signed [lct_pkg::RAW_W-1:0]     i_sample,
    input  logic signed [lct_pkg::RAW_W-1:0]     i_load_value,
    input  logic signed [lct_pkg::SCALE_W-1:0]   i_scale,
    output logic signed [lct_pkg::RAW_W-1:0]     o_raw,
    output logic signed [lct_pkg::WEIGHT_W-1:0]  o_weight
);

    localparam int RAW_W  = lct_pkg::RAW_W;
    localparam int ACC_W  = RAW_W + $clog2(TARE_SAMPLES + 1);
    localparam int MAG_W  = ACC_W - 1;
    localparam int PRD_W  = 2 * MAG_W + 1;
    localparam logic [MAG_W:0] RECIP = (MAG_W + 1)'((64'd1 << MAG_W) / TARE_SAMPLES);
    localparam logic [MAG_W-1:0] DIVISOR = MAG_W'(TARE_SAMPLES);

    logic signed [RAW_W-1:0]  r_raw_store;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [RAW_W-1:0]  r_offset;

    logic signed [ACC_W-1:0]  n_acc;
    logic signed [ACC_W-1:0]  acc_neg;
    logic [MAG_W-1:0]         acc_mag;
    logic signed [RAW_W-1:0]  raw_now;

    // stage 1
    logic signed [RAW_W-1:0]  r_p1_raw;
    logic [MAG_W-1:0]         r_p1_mag;
    logic                     r_p1_neg;
    logic                     r_p1_fin;
    logic                     r_p1_load;
    logic signed [RAW_W-1:0]  r_p1_ldv;
    // stage 2
    logic signed [RAW_W-1:0]  r_p2_raw;
    logic [MAG_W-1:0]         r_p2_mag;
    logic                     r_p2_neg;
    logic                     r_p2_fin;
    logic                     r_p2_load;
    logic signed [RAW_W-1:0]  r_p2_ldv;
    logic [PRD_W-1:0]         r_p2_prod;
    // stage 3
    logic signed [RAW_W-1:0]  r_p3_raw;
    logic [MAG_W-1:0]         r_p3_mag;
    logic                     r_p3_neg;
    logic                     r_p3_fin;
    logic                     r_p3_load;
    logic signed [RAW_W-1:0]  r_p3_ldv;
    logic [MAG_W-1:0]         r_p3_q0;
    logic [MAG_W-1:0]         r_p3_q0d;
    // stages 4 to 6
    logic signed [RAW_W-1:0]             r_p4_raw;
    logic signed [RAW_W-1:0]             r_p5_raw;
    logic signed [lct_pkg::DIFF_W-1:0]   r_p5_diff;
    logic signed [RAW_W-1:0]             r_p6_raw;
    logic signed [lct_pkg::PROD_W-1:0]   r_p6_prod;

    logic [MAG_W-1:0]         q0;
    logic [MAG_W-1:0]         rem;
    logic [MAG_W-1:0]         quo;
    logic [MAG_W-1:0]         quo_s;
    logic [lct_pkg::SH_W-1:0] sh;
    logic                     ovf;
    logic signed [lct_pkg::WEIGHT_W-1:0] sat;

    assign n_acc   = r_acc + ACC_W'(i_sample);
    assign acc_neg = -n_acc;
    assign acc_mag = n_acc[ACC_W-1] ? acc_neg[MAG_W-1:0] : n_acc[MAG_W-1:0];
    assign raw_now = i_ctl.frame ? i_sample : r_raw_store;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw_store <= '0;
            r_acc       <= '0;
        end else if (i_ctl.adv[0]) begin
            if (i_ctl.frame) begin
                r_raw_store <= i_sample;
            end
            if (i_ctl.clear) begin
                r_acc <= '0;
            end else if (i_ctl.accum) begin
                r_acc <= n_acc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv[0]) begin
            r_p1_raw  <= raw_now;
            r_p1_mag  <= acc_mag;
            r_p1_neg  <= n_acc[ACC_W-1];
            r_p1_fin  <= i_ctl.fin;
            r_p1_load <= i_ctl.load;
            r_p1_ldv  <= i_load_value;
        end
        // reciprocal estimate of the tare mean, low by at most one
        if (i_ctl.adv[1]) begin
            r_p2_raw  <= r_p1_raw;
            r_p2_mag  <= r_p1_mag;
            r_p2_neg  <= r_p1_neg;
            r_p2_fin  <= r_p1_fin;
            r_p2_load <= r_p1_load;
            r_p2_ldv  <= r_p1_ldv;
            r_p2_prod <= PRD_W'(r_p1_mag) * PRD_W'(RECIP);
        end
        if (i_ctl.adv[2]) begin
            r_p3_raw  <= r_p2_raw;
            r_p3_mag  <= r_p2_mag;
            r_p3_neg  <= r_p2_neg;
            r_p3_fin  <= r_p2_fin;
            r_p3_load <= r_p2_load;
            r_p3_ldv  <= r_p2_ldv;
            r_p3_q0   <= q0;
            r_p3_q0d  <= q0 * DIVISOR;
        end
        if (i_ctl.adv[3]) begin
            r_p4_raw <= r_p3_raw;
        end
        // offset already holds this beat's update here
        if (i_ctl.adv[4]) begin
            r_p5_raw  <= r_p4_raw;
            r_p5_diff <= lct_pkg::DIFF_W'(r_p4_raw) - lct_pkg::DIFF_W'(r_offset);
        end
        if (i_ctl.adv[5]) begin
            r_p6_raw  <= r_p5_raw;
            r_p6_prod <= r_p5_diff * i_scale;
        end
        if (i_ctl.adv[6]) begin
            o_raw    <= r_p6_raw;
            o_weight <= sat;
        end
    end

    assign q0    = r_p2_prod[2*MAG_W-1:MAG_W];
    assign rem   = r_p3_mag - r_p3_q0d;
    assign quo   = r_p3_q0 + MAG_W'(rem >= DIVISOR);
    assign quo_s = r_p3_neg ? (~quo + 1'b1) : quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= RAW_W'(DEFAULT_OFFSET);
        end else if (i_ctl.adv[3]) begin
            if (r_p3_fin) begin
                r_offset <= quo_s[RAW_W-1:0];
            end else if (r_p3_load) begin
                r_offset <= r_p3_ldv;
            end
        end
    end

    // floor shift is the plain arithmetic drop of the low bits
    assign sh  = r_p6_prod[lct_pkg::PROD_W-1:lct_pkg::FRAC_SHIFT];
    assign ovf = !((&sh[lct_pkg::SH_W-1:lct_pkg::WEIGHT_W-1]) ||
                   !(|sh[lct_pkg::SH_W-1:lct_pkg::WEIGHT_W-1]));

    always_comb begin
        if (ovf) begin
            sat = sh[lct_pkg::SH_W-1] ? {1'b1, {(lct_pkg::WEIGHT_W-1){1'b0}}}
                                      : {1'b0, {(lct_pkg::WEIGHT_W-1){1'b1}}};
        end else begin
            sat = sh[lct_pkg::WEIGHT_W-1:0];
        end
    end

endmodule

### hw/rtl/lct_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lct_merge
// Sums the corner weights and holds the result beat in the output register.
// ----------------------------------------------------------------------------
module lct_merge (
    input  logic                                   i_clk,
    input  logic                                   i_load,
    input  logic [lct_pkg::RAW_W-1:0]              i_raw    [lct_pkg::FIELD_CORNERS],
    input  logic [lct_pkg::WEIGHT_W-1:0]           i_weight [lct_pkg::FIELD_CORNERS],
    input  lct_pkg::t_status                       i_status,
    output logic [lct_pkg::OUT_TDATA_W-1:0]        o_tdata
);

    localparam int TOTAL_W = lct_pkg::TOTAL_W;
    localparam int W_W     = lct_pkg::WEIGHT_W;

    logic [TOTAL_W-1:0] total;

    always_comb begin
        total = '0;
        for (int c = 0; c < lct_pkg::FIELD_CORNERS; c++) begin
            total = total + {{(TOTAL_W-W_W){i_weight[c][W_W-1]}}, i_weight[c]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            o_tdata <= {4'b0000, i_status.seen, i_status.busy, total,
                        i_weight[3], i_weight[2], i_weight[1], i_weight[0],
                        i_raw[3], i_raw[2], i_raw[1], i_raw[0]};
        end
    end

endmodule

### hw/rtl/load_cell_tare_scale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// load_cell_tare_scale
// Path: an input beat passes the lane stages and then the merge output register.
// Throughput: one item per cycle when unstalled, set by the eight-stage pipeline in
//   which each corner lane has two multipliers for the tare divide and one for the scale.
// Reset: synchronous, active low; clears raw values, accumulators, tare state
//   and pipeline valids, loads offsets with DEFAULT_OFFSET and scales with 65536.0.
// ----------------------------------------------------------------------------
module load_cell_tare_scale #(
    parameter int NUM_CORNERS    = lct_pkg::NUM_CORNERS_DEF,
    parameter int TARE_SAMPLES   = lct_pkg::TARE_SAMPLES_DEF,
    parameter int DEFAULT_OFFSET = lct_pkg::DEFAULT_OFFSET_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // sample_corner0..3, corner_index, offset_value, zero pad
    input  logic [lct_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // opcode
    input  logic [lct_pkg::OP_W-1:0]            s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // raw_corner0..3, weight_corner0..3, weight_total, tare_busy, data_seen, zero pad
    output logic [lct_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [lct_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [lct_pkg::SCALE_W-1:0]         i_cfg_data
);

    localparam int PIPE_D  = lct_pkg::PIPE_D;
    localparam int RAW_W   = lct_pkg::RAW_W;
    localparam int REM_W   = lct_pkg::REM_W;
    localparam int NC      = lct_pkg::FIELD_CORNERS;

    logic [lct_pkg::SCALE_W-1:0] r_scale [NC];
    logic [REM_W-1:0]            r_tare_rem;
    logic                        r_tare_run;
    logic                        r_have;
    logic [REM_W-1:0]            n_tare_rem;
    logic                        n_tare_run;
    logic                        n_have;
    logic [REM_W-1:0]            rem_dec;

    logic [PIPE_D-1:0]           r_vld;
    logic [PIPE_D-1:0]           n_vld;
    logic [PIPE_D-1:0]           en;
    logic [PIPE_D-1:0]           src;
    logic [PIPE_D-1:0]           adv;
    lct_pkg::t_status            r_stat [PIPE_D-1];

    logic                        accept;
    logic [lct_pkg::OP_W-1:0]    opcode;
    logic [lct_pkg::IDX_W-1:0]   corner_index;
    logic [RAW_W-1:0]            offset_value;
    logic [RAW_W-1:0]            sample [NC];

    lct_pkg::t_lane_ctl          base_ctl;
    lct_pkg::t_lane_ctl          lane_ctl [NC];
    logic [RAW_W-1:0]            lane_raw [NC];
    logic [lct_pkg::WEIGHT_W-1:0] lane_weight [NC];

    assign opcode       = s_axis_tuser;
    assign corner_index = s_axis_tdata[97:96];
    assign offset_value = s_axis_tdata[121:98];
    assign sample[0]    = s_axis_tdata[23:0];
    assign sample[1]    = s_axis_tdata[47:24];
    assign sample[2]    = s_axis_tdata[71:48];
    assign sample[3]    = s_axis_tdata[95:72];

    // pipeline flow: a stage loads when empty or when its beat moves on
    always_comb begin
        en[PIPE_D-1] = !r_vld[PIPE_D-1] || m_axis_tready;
        for (int k = PIPE_D - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
        src[0] = s_axis_tvalid;
        for (int k = 1; k < PIPE_D; k++) begin
            src[k] = r_vld[k-1];
        end
        adv   = en & src;
        n_vld = r_vld;
        for (int k = 0; k < PIPE_D; k++) begin
            if (en[k]) begin
                n_vld[k] = src[k];
            end
        end
    end

    assign s_axis_tready = en[0];
    assign accept        = adv[0];
    assign m_axis_tvalid = r_vld[PIPE_D-1];
    assign o_cfg_ready   = 1'b1;
    assign rem_dec       = r_tare_rem - 1'b1;

    always_comb begin
        n_tare_rem     = r_tare_rem;
        n_tare_run     = r_tare_run;
        n_have         = r_have;
        base_ctl       = '0;
        base_ctl.adv   = adv[lct_pkg::LANE_D-1:0];
        if (accept) begin
            case (opcode)
                lct_pkg::OP_FRAME: begin
                    n_have         = 1'b1;
                    base_ctl.frame = 1'b1;
                    if (r_tare_run) begin
                        base_ctl.accum = 1'b1;
                        n_tare_rem     = rem_dec;
                        if (rem_dec == '0) begin
                            base_ctl.fin = 1'b1;
                            n_tare_run   = 1'b0;
                        end
                    end
                end
                lct_pkg::OP_TARE: begin
                    base_ctl.clear = 1'b1;
                    n_tare_rem     = REM_W'(TARE_SAMPLES);
                    n_tare_run     = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        for (int c = 0; c < NC; c++) begin
            lane_ctl[c]      = base_ctl;
            lane_ctl[c].load = accept && (opcode == lct_pkg::OP_LOAD) &&
                               (corner_index == lct_pkg::IDX_W'(c));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= '0;
            r_tare_rem <= '0;
            r_tare_run <= 1'b0;
            r_have     <= 1'b0;
        end else begin
            r_vld      <= n_vld;
            r_tare_rem <= n_tare_rem;
            r_tare_run <= n_tare_run;
            r_have     <= n_have;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NC; c++) begin
                r_scale[c] <= lct_pkg::SCALE_RESET;
            end
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                lct_pkg::REG_SCALE0: r_scale[0] <= i_cfg_data;
                lct_pkg::REG_SCALE1: r_scale[1] <= i_cfg_data;
                lct_pkg::REG_SCALE2: r_scale[2] <= i_cfg_data;
                lct_pkg::REG_SCALE3: r_scale[3] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // status flags ride alongside the lane stages
    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_stat[0].busy <= n_tare_run;
            r_stat[0].seen <= n_have;
        end
        for (int k = 1; k < PIPE_D - 1; k++) begin
            if (adv[k]) begin
                r_stat[k] <= r_stat[k-1];
            end
        end
    end

    for (genvar c = 0; c < NC; c++) begin : g_lane
        if (c < NUM_CORNERS) begin : g_live
            lct_lane #(
                .TARE_SAMPLES   (TARE_SAMPLES),
                .DEFAULT_OFFSET (DEFAULT_OFFSET)
            ) u_lane (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (lane_ctl[c]),
                .i_sample     (sample[c]),
                .i_load_value (offset_value),
                .i_scale      (r_scale[c]),
                .o_raw        (lane_raw[c]),
                .o_weight     (lane_weight[c])
            );
        end else begin : g_dead
            assign lane_raw[c]    = '0;
            assign lane_weight[c] = '0;
        end
    end

    lct_merge u_merge (
        .i_clk    (i_clk),
        .i_load   (adv[PIPE_D-1]),
        .i_raw    (lane_raw),
        .i_weight (lane_weight),
        .i_status (r_stat[PIPE_D-2]),
        .o_tdata  (m_axis_tdata)
    );

endmodule

### hw/rtl/lct_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lct_checker
// Port-level checks on the result stream of the tare and scale block.
// ----------------------------------------------------------------------------
module lct_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [lct_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    logic [lct_pkg::TOTAL_W-1:0] sum_w;

    assign sum_w = {{2{m_axis_tdata[127]}}, m_axis_tdata[127:96]} +
                   {{2{m_axis_tdata[159]}}, m_axis_tdata[159:128]} +
                   {{2{m_axis_tdata[191]}}, m_axis_tdata[191:160]} +
                   {{2{m_axis_tdata[223]}}, m_axis_tdata[223:192]};

    // no result beat straight out of reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result beat valid right after reset");

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("stalled result beat dropped");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("stalled result beat changed");

    a_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[257:224] == sum_w)
        else $error("weight total differs from corner sum");

    // once a frame has been seen it stays seen until reset
    a_seen_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tdata[259]
        |=> !m_axis_tvalid || m_axis_tdata[259])
        else $error("data seen flag fell");

endmodule

bind load_cell_tare_scale lct_checker u_lct_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
